// ===== rtl/afc_pkg.sv =====
`default_nettype none
package afc_pkg;

  // Fixed-point format of every matrix entry and vector component
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  // Product after the floor shift, and the sum of three products plus position
  localparam int SH_W      = PROD_W - FRAC_BITS;
  localparam int SUM_W     = SH_W + 2;

  localparam int NUM_ROWS  = 3;
  localparam int NUM_COLS  = 4;
  localparam int MAT_DEPTH = NUM_ROWS * NUM_COLS;

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic [1:0]               col_t;

  // Item kinds
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MUL  = 1'b1;

  // Column codes
  localparam col_t COL_RIGHT = 2'd0;
  localparam col_t COL_FWD   = 2'd1;
  localparam col_t COL_UP    = 2'd2;
  localparam col_t COL_POS   = 2'd3;

  localparam fix_t FIX_ONE   = fix_t'(1) << FRAC_BITS;
  localparam fix_t FIX_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam fix_t FIX_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

  // Pipeline control from the multiply stage to the output stage
  typedef struct packed {
    logic vld;
    col_t col;
  } afc_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/afc_lane.sv =====
`default_nettype none
module afc_lane (
  input  wire logic          clk,
  input  wire logic          load_en,
  input  wire afc_pkg::fix_t a_c0,
  input  wire afc_pkg::fix_t a_c1,
  input  wire afc_pkg::fix_t a_c2,
  input  wire afc_pkg::fix_t a_pos,
  input  wire logic          add_pos,
  input  wire afc_pkg::fix_t b_x,
  input  wire afc_pkg::fix_t b_y,
  input  wire afc_pkg::fix_t b_z,
  output afc_pkg::fix_t      res,
  output logic               clip
);
  import afc_pkg::*;

  logic signed [PROD_W-1:0] p0, p1, p2;
  logic signed [SH_W-1:0]   pr0_r, pr1_r, pr2_r;
  fix_t                     pos_r;
  logic signed [SUM_W-1:0]  sum;

  // Exact 32x32 products of one row of the basis with the column
  assign p0 = PROD_W'(a_c0) * PROD_W'(b_x);
  assign p1 = PROD_W'(a_c1) * PROD_W'(b_y);
  assign p2 = PROD_W'(a_c2) * PROD_W'(b_z);

  // Register products shifted down with floor rounding, and the position term
  always_ff @(posedge clk) begin
    if (load_en) begin
      pr0_r <= p0[PROD_W-1:FRAC_BITS];
      pr1_r <= p1[PROD_W-1:FRAC_BITS];
      pr2_r <= p2[PROD_W-1:FRAC_BITS];
      pos_r <= add_pos ? a_pos : '0;
    end
  end

  // Sum exactly, then clip to the 32-bit range
  assign sum = SUM_W'(pr0_r) + SUM_W'(pr1_r) + SUM_W'(pr2_r) + SUM_W'(pos_r);

  always_comb begin
    clip = (sum[SUM_W-1:DATA_W-1] != '0) && (sum[SUM_W-1:DATA_W-1] != '1);
    if (clip) begin
      res = sum[SUM_W-1] ? FIX_MIN : FIX_MAX;
    end else begin
      res = sum[DATA_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/afc_merge.sv =====
`default_nettype none
module afc_merge (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire afc_pkg::afc_ctl_t ctl,
  input  wire afc_pkg::fix_t     lane_res [afc_pkg::NUM_ROWS],
  input  wire logic [afc_pkg::NUM_ROWS-1:0] lane_clip,
  output logic                   take_ok,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output afc_pkg::fix_t          res_x,
  output afc_pkg::fix_t          res_y,
  output afc_pkg::fix_t          res_z,
  output afc_pkg::col_t          res_col,
  output logic                   res_sat
);
  import afc_pkg::*;

  logic out_v_r, out_v_nxt;
  fix_t x_r, y_r, z_r;
  col_t col_r;
  logic sat_r;

  // Output register is free or being emptied this cycle
  assign take_ok   = !out_v_r || out_ready;
  assign out_v_nxt = take_ok ? ctl.vld : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  // Capture the lanes and fold their clip flags into one
  always_ff @(posedge clk) begin
    if (take_ok && ctl.vld) begin
      x_r   <= lane_res[0];
      y_r   <= lane_res[1];
      z_r   <= lane_res[2];
      col_r <= ctl.col;
      sat_r <= |lane_clip;
    end
  end

  assign out_valid = out_v_r;
  assign res_x     = x_r;
  assign res_y     = y_r;
  assign res_z     = z_r;
  assign res_col   = col_r;
  assign res_sat   = sat_r;

endmodule
`default_nettype wire

// ===== rtl/affine_transform_compose_top.sv =====
`default_nettype none
// Composes 4x3 affine transforms one column at a time in signed Q16.16.
// A load item (cmd 0) overwrites one column of the stored matrix A and gives
// no result; the next item already sees it. A multiply item (cmd 1) carries one
// column of B and gives one result: A's basis times the column, plus A's
// position for the position column, each product floored by 16 bits and each
// sum clipped to 32 bits with a flag. Feed B's four columns to get A*B. One
// item is taken every cycle, since each of the three row lanes has its own
// 32x32 multipliers and nothing is shared between items. A result passes
// through the register behind the multipliers, then the output register
// behind the merge. While the result side stalls with both registers full,
// the input stalls as well. After reset A holds the identity basis and a zero
// position.
module affine_transform_compose_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [95:0]  in_tdata,   // vec_x[31:0], vec_y[63:32], vec_z[95:64]
  input  wire logic [2:0]   in_tuser,   // cmd[0], column[2:1]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata,  // res_x[31:0], res_y[63:32], res_z[95:64]
  output logic [2:0]        out_tuser   // out_column[1:0], saturated[2]
);
  import afc_pkg::*;

  logic     in_cmd;
  col_t     in_col;
  fix_t     in_vec [NUM_ROWS];
  fix_t     mat_r  [MAT_DEPTH];
  logic     in_acc, load_acc, mul_acc;
  logic     s1_v_r, s1_v_nxt, s1_adv, take_ok;
  col_t     s1_col_r;
  logic     add_pos;
  afc_ctl_t ctl;
  fix_t     lane_res  [NUM_ROWS];
  logic [NUM_ROWS-1:0] lane_clip;
  fix_t     rx, ry, rz;
  col_t     rcol;
  logic     rsat;

  // Unpack the item
  assign in_cmd    = in_tuser[0];
  assign in_col    = in_tuser[2:1];
  assign in_vec[0] = in_tdata[31:0];
  assign in_vec[1] = in_tdata[63:32];
  assign in_vec[2] = in_tdata[95:64];

  // Handshake: stage one takes an item when empty or when it moves on
  assign s1_adv    = s1_v_r && take_ok;
  assign in_tready = !s1_v_r || take_ok;
  assign in_acc    = in_tvalid && in_tready;
  assign load_acc  = in_acc && (in_cmd == CMD_LOAD);
  assign mul_acc   = in_acc && (in_cmd == CMD_MUL);
  assign add_pos   = (in_col == COL_POS);

  assign s1_v_nxt  = mul_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_acc) begin
      s1_col_r <= in_col;
    end
  end

  // Stored matrix A, entry column*3 + component; reset to identity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_DEPTH; i++) begin
        mat_r[i] <= (i % (NUM_ROWS + 1) == 0 && i < NUM_ROWS * NUM_ROWS) ? FIX_ONE : '0;
      end
    end else if (load_acc) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        if (in_col == col_t'(c)) begin
          for (int k = 0; k < NUM_ROWS; k++) begin
            mat_r[c*NUM_ROWS + k] <= in_vec[k];
          end
        end
      end
    end
  end

  // One lane per result row
  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
    afc_lane u_lane (
      .clk     (clk),
      .load_en (mul_acc),
      .a_c0    (mat_r[r]),
      .a_c1    (mat_r[NUM_ROWS + r]),
      .a_c2    (mat_r[2*NUM_ROWS + r]),
      .a_pos   (mat_r[3*NUM_ROWS + r]),
      .add_pos (add_pos),
      .b_x     (in_vec[0]),
      .b_y     (in_vec[1]),
      .b_z     (in_vec[2]),
      .res     (lane_res[r]),
      .clip    (lane_clip[r])
    );
  end

  assign ctl = '{vld: s1_v_r, col: s1_col_r};

  // Combine lanes into the output register
  afc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .lane_res  (lane_res),
    .lane_clip (lane_clip),
    .take_ok   (take_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_x     (rx),
    .res_y     (ry),
    .res_z     (rz),
    .res_col   (rcol),
    .res_sat   (rsat)
  );

  assign out_tdata = {rz, ry, rx};
  assign out_tuser = {rsat, rcol};

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
  import afc_pkg::*;

  // One result column as it leaves the block
  typedef struct packed {
    col_t col;
    fix_t x;
    fix_t y;
    fix_t z;
    logic sat;
  } col_out_t;

  // One item to send, with an optional hand-typed expected result
  typedef struct packed {
    logic     cmd;
    col_t     col;
    fix_t     x;
    fix_t     y;
    fix_t     z;
    logic     typed;
    col_out_t res;
  } stim_row_t;

  localparam int NUM_DIR    = 25;
  localparam int NUM_RAND   = 1150;
  localparam int MAX_REPORT = 10;
  localparam int DRAIN_CYC  = 16;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [2:0]  out_tuser;

  // Shadow copy of the stored left matrix, entry column*3 + component
  fix_t      lhs_mat [MAT_DEPTH];
  col_out_t  pending_cols [$];
  stim_row_t dir_tab [NUM_DIR];
  int        mismatches = 0;
  bit        idle_en    = 1'b1;
  int        ready_left = 0;
  logic      ready_now  = 1'b1;

  affine_transform_compose_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // A's basis times column b, plus A's position for the position column
  function automatic col_out_t compose_column(input col_t col, input fix_t bx, input fix_t by,
                                              input fix_t bz);
    fix_t     b [3];
    fix_t     res [3];
    longint   acc;
    int       row;
    int       k;
    col_out_t r;
    b[0] = bx;
    b[1] = by;
    b[2] = bz;
    r = '0;
    r.col = col;
    for (row = 0; row < NUM_ROWS; row++) begin
      acc = 0;
      for (k = 0; k < NUM_ROWS; k++) begin
        acc += (longint'(lhs_mat[k*NUM_ROWS + row]) * longint'(b[k])) >>> FRAC_BITS;
      end
      if (col == COL_POS) begin
        acc += longint'(lhs_mat[COL_POS*NUM_ROWS + row]);
      end
      // Clip to 32 bits and flag it
      if (acc > longint'(FIX_MAX)) begin
        res[row] = FIX_MAX;
        r.sat = 1'b1;
      end else if (acc < longint'(FIX_MIN)) begin
        res[row] = FIX_MIN;
        r.sat = 1'b1;
      end else begin
        res[row] = fix_t'(acc);
      end
    end
    r.x = res[0];
    r.y = res[1];
    r.z = res[2];
    return r;
  endfunction

  function automatic stim_row_t mk(input logic cmd, input col_t col, input fix_t x,
                                   input fix_t y, input fix_t z);
    stim_row_t s;
    s = '0;
    s.cmd = cmd;
    s.col = col;
    s.x = x;
    s.y = y;
    s.z = z;
    return s;
  endfunction

  // Multiply item whose result can be read off directly
  function automatic stim_row_t mk_exp(input col_t col, input fix_t x, input fix_t y,
                                       input fix_t z, input fix_t ex, input fix_t ey,
                                       input fix_t ez, input logic esat);
    stim_row_t s;
    s = mk(CMD_MUL, col, x, y, z);
    s.typed = 1'b1;
    s.res = '{col, ex, ey, ez, esat};
    return s;
  endfunction

  // Mostly modest magnitudes when narrow, with extremes and raw bits mixed in
  function automatic fix_t pick_value(input bit narrow);
    case ($urandom_range(0, narrow ? 15 : 7))
      0:       return FIX_MAX;
      1:       return FIX_MIN;
      2:       return '0;
      3:       return fix_t'($urandom);
      4:       return $urandom_range(0, 1) ? FIX_ONE : -FIX_ONE;
      5:       return fix_t'($urandom_range(0, 255)) - fix_t'(128);
      default: return fix_t'($urandom_range(0, 32'h000F_FFFF)) - fix_t'(32'h0008_0000);
    endcase
  endfunction

  function automatic stim_row_t rand_item(input logic cmd, input col_t col, input bit narrow);
    return mk(cmd, col, pick_value(narrow), pick_value(narrow), pick_value(narrow));
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item, hold it until taken, then update the shadow or queue its result
  task automatic send_item(input stim_row_t it);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {it.z, it.y, it.x};
    in_tuser  <= {it.col, it.cmd};
    do @(posedge clk); while (!in_tready);
    if (it.cmd == CMD_LOAD) begin
      lhs_mat[it.col*NUM_ROWS + 0] = it.x;
      lhs_mat[it.col*NUM_ROWS + 1] = it.y;
      lhs_mat[it.col*NUM_ROWS + 2] = it.z;
    end else begin
      pending_cols.push_back(it.typed ? it.res : compose_column(it.col, it.x, it.y, it.z));
    end
  endtask

  // Stop sending until every pending result has come out
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_cols.size() != 0) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORT) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // Result side: random stalls, with stall-free stretches when idling is off
  always @(negedge clk) begin
    if (ready_left == 0) begin
      if (idle_en && $urandom_range(0, 99) < 30) begin
        ready_now  = 1'b0;
        ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      end else begin
        ready_now  = 1'b1;
        ready_left = $urandom_range(1, 8);
      end
    end else begin
      ready_left--;
    end
    out_tready <= ready_now;
  end

  // Compare each taken result with the oldest pending one
  always @(posedge clk) begin
    col_out_t got;
    col_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.col = out_tuser[1:0];
      got.sat = out_tuser[2];
      got.x   = out_tdata[31:0];
      got.y   = out_tdata[63:32];
      got.z   = out_tdata[95:64];
      if (pending_cols.size() == 0) begin
        flag_mismatch("unrequested result, res_x", '0, got.x);
      end else begin
        want = pending_cols.pop_front();
        if (got.col !== want.col) flag_mismatch("out_column", 32'(want.col), 32'(got.col));
        if (got.x !== want.x) flag_mismatch("res_x", want.x, got.x);
        if (got.y !== want.y) flag_mismatch("res_y", want.y, got.y);
        if (got.z !== want.z) flag_mismatch("res_z", want.z, got.z);
        if (got.sat !== want.sat) flag_mismatch("saturated", 32'(want.sat), 32'(got.sat));
      end
    end
  end

  initial begin
    int  i;
    int  k;
    int  sent;
    int  n_load;
    bit  mid_drained;

    // Identity basis, zero position
    foreach (lhs_mat[j]) lhs_mat[j] = '0;
    lhs_mat[0] = FIX_ONE;
    lhs_mat[4] = FIX_ONE;
    lhs_mat[8] = FIX_ONE;

    // Identity after reset: basis columns and the position column pass through
    dir_tab[0]  = mk_exp(COL_RIGHT, 32'h0001_0000, 32'h0002_8000, 32'hFFFD_0000,
                         32'h0001_0000, 32'h0002_8000, 32'hFFFD_0000, 1'b0);
    dir_tab[1]  = mk_exp(COL_POS, FIX_MAX, FIX_MIN, '0, FIX_MAX, FIX_MIN, '0, 1'b0);
    dir_tab[2]  = mk_exp(COL_FWD, fix_t'(-1), fix_t'(-1), fix_t'(-1),
                         fix_t'(-1), fix_t'(-1), fix_t'(-1), 1'b0);
    dir_tab[3]  = mk_exp(COL_UP, fix_t'(1), '0, '0, fix_t'(1), '0, '0, 1'b0);
    // Full-scale basis: clip high, clip low, and zero
    dir_tab[4]  = mk(CMD_LOAD, COL_RIGHT, FIX_MAX, FIX_MAX, FIX_MAX);
    dir_tab[5]  = mk(CMD_LOAD, COL_FWD, FIX_MAX, FIX_MAX, FIX_MAX);
    dir_tab[6]  = mk(CMD_LOAD, COL_UP, FIX_MAX, FIX_MAX, FIX_MAX);
    dir_tab[7]  = mk_exp(COL_RIGHT, FIX_MAX, FIX_MAX, FIX_MAX,
                         FIX_MAX, FIX_MAX, FIX_MAX, 1'b1);
    dir_tab[8]  = mk_exp(COL_FWD, FIX_MIN, FIX_MIN, FIX_MIN,
                         FIX_MIN, FIX_MIN, FIX_MIN, 1'b1);
    dir_tab[9]  = mk_exp(COL_UP, '0, '0, '0, '0, '0, '0, 1'b0);
    // Position added only on the position column, clipping against it
    dir_tab[10] = mk(CMD_LOAD, COL_POS, FIX_MAX, FIX_MIN, '0);
    dir_tab[11] = mk_exp(COL_POS, '0, '0, '0, FIX_MAX, FIX_MIN, '0, 1'b0);
    dir_tab[12] = mk(CMD_MUL, COL_POS, fix_t'(1), '0, '0);
    dir_tab[13] = mk(CMD_MUL, COL_POS, fix_t'(-1), '0, '0);
    // Floor rounding of negative products
    dir_tab[14] = mk(CMD_LOAD, COL_RIGHT, fix_t'(-1), fix_t'(1), FIX_MIN);
    dir_tab[15] = mk(CMD_LOAD, COL_FWD, FIX_ONE, -FIX_ONE, 32'h0000_8000);
    dir_tab[16] = mk(CMD_LOAD, COL_UP, FIX_MAX, '0, 32'hFFFF_0001);
    dir_tab[17] = mk(CMD_MUL, COL_RIGHT, 32'h0001_0001, fix_t'(-1), 32'h0001_8000);
    dir_tab[18] = mk(CMD_MUL, COL_UP, FIX_MIN, FIX_MIN, FIX_MIN);
    dir_tab[19] = mk(CMD_MUL, COL_POS, FIX_MAX, FIX_MIN, fix_t'(-1));
    // Back to identity
    dir_tab[20] = mk(CMD_LOAD, COL_POS, '0, '0, '0);
    dir_tab[21] = mk(CMD_LOAD, COL_RIGHT, FIX_ONE, '0, '0);
    dir_tab[22] = mk(CMD_LOAD, COL_FWD, '0, FIX_ONE, '0);
    dir_tab[23] = mk(CMD_LOAD, COL_UP, '0, '0, FIX_ONE);
    dir_tab[24] = mk_exp(COL_POS, 32'h1234_5678, 32'h8765_4321, fix_t'(1),
                         32'h1234_5678, 32'h8765_4321, fix_t'(1), 1'b0);

    // Hold reset, release on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NUM_DIR; i++) send_item(dir_tab[i]);
    drain_results();

    // Random part: mostly loads of A followed by all four columns of B
    sent = 0;
    mid_drained = 1'b0;
    while (sent < NUM_RAND) begin
      idle_en = !(sent >= 350 && sent < 500);
      if (sent >= 700 && !mid_drained) begin
        drain_results();
        mid_drained = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        n_load = $urandom_range(0, 4);
        repeat (n_load) send_item(rand_item(CMD_LOAD, col_t'($urandom_range(0, 3)), 1'b1));
        for (k = 0; k < NUM_COLS; k++) send_item(rand_item(CMD_MUL, col_t'(k), 1'b1));
        sent += n_load + NUM_COLS;
      end else begin
        send_item(rand_item(logic'($urandom_range(0, 1)), col_t'($urandom_range(0, 3)), 1'b0));
        sent++;
      end
    end

    // Let the pipeline empty, then a few more cycles for strays
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_cols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/afc_pkg.sv
rtl/afc_lane.sv
rtl/afc_merge.sv
rtl/affine_transform_compose_top.sv
tb/tb_top.sv
